>>> sv/mte_pkg.sv
// Shared types and constants for the MIDI track event encoder.
`default_nettype none

package mte_pkg;

    localparam int MAX_BYTES = 9;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int IDX_W     = $clog2(MAX_BYTES);
    localparam int VLQ_MAX   = 4;

    localparam logic [7:0]  SYSEX_STATUS = 8'hF0;
    localparam logic [7:0]  META_STATUS  = 8'hFF;
    localparam logic [7:0]  EOT_TYPE     = 8'h2F;
    localparam logic [7:0]  ZERO_BYTE    = 8'h00;
    localparam logic [27:0] VLQ_GT3      = 28'hfe00000;
    localparam logic [27:0] VLQ_GT2      = 28'hfffc000;
    localparam logic [27:0] VLQ_GT1      = 28'hfffff80;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_END   = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [VLQ_MAX-1:0][7:0] bytes;
        logic [2:0]              n;
    } vlq_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
        logic [31:0]               base;
    } burst_t;

    // Bytes of a VLQ, most significant group first.
    function automatic vlq_t vlq_enc(input logic [27:0] v);
        vlq_t       r;
        logic [2:0] pos;
        if ((v & VLQ_GT3) != 28'd0) begin
            r.n = 3'd4;
        end else if ((v & VLQ_GT2) != 28'd0) begin
            r.n = 3'd3;
        end else if ((v & VLQ_GT1) != 28'd0) begin
            r.n = 3'd2;
        end else begin
            r.n = 3'd1;
        end
        for (int k = 0; k < VLQ_MAX; k++) begin
            pos = r.n - 3'd1 - 3'(k);
            r.bytes[k] = {(3'(k) != r.n - 3'd1), v[7 * pos[1:0] +: 7]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/mte_encoder.sv
// Event encoder: tick delta, sysex header, data byte and end-of-track bytes into a burst register.
`default_nettype none

module mte_encoder
    import mte_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] tick,
    input  wire logic        sysex,
    input  wire logic [27:0] msg_length,
    input  wire logic [7:0]  data_byte,
    input  wire logic        pop,
    output burst_t           burst,
    output logic             burst_valid
);

    logic [31:0] prev_tick_reg, prev_tick_next;
    logic        started_reg, started_next;
    logic [31:0] byte_total_reg, byte_total_next;
    burst_t      burst_reg, burst_next;
    logic        burst_valid_reg, burst_valid_next;

    logic [27:0] delta;
    vlq_t        vlq_d, vlq_l;
    logic        accept;
    cmd_t        cmd_c;

    assign in_ready    = !burst_valid_reg || pop;
    assign accept      = in_valid && in_ready;
    assign burst       = burst_reg;
    assign burst_valid = burst_valid_reg;
    assign cmd_c       = cmd_t'(cmd);

    assign delta = 28'(tick - (started_reg ? prev_tick_reg : tick));
    assign vlq_d = vlq_enc(delta);
    assign vlq_l = vlq_enc(msg_length);

    always_comb begin
        logic [3:0] off;
        off              = '0;
        prev_tick_next   = prev_tick_reg;
        started_next     = started_reg;
        byte_total_next  = byte_total_reg;
        burst_next       = burst_reg;
        burst_valid_next = burst_valid_reg && !pop;
        if (accept) begin
            burst_next.base  = byte_total_reg;
            burst_next.bytes = '0;
            burst_next.cnt   = '0;
            unique case (cmd_c)
                CMD_START: begin
                    started_next   = 1'b1;
                    prev_tick_next = tick;
                    for (int p = 0; p < MAX_BYTES; p++) begin
                        off = 4'(p) - {1'b0, vlq_d.n} - 4'd1;
                        if (4'(p) < {1'b0, vlq_d.n}) begin
                            burst_next.bytes[p] = vlq_d.bytes[p[1:0]];
                        end else if (4'(p) == {1'b0, vlq_d.n}) begin
                            burst_next.bytes[p] = SYSEX_STATUS;
                        end else begin
                            burst_next.bytes[p] = vlq_l.bytes[off[1:0]];
                        end
                    end
                    burst_next.cnt = sysex ? CNT_W'(vlq_d.n) + CNT_W'(vlq_l.n) + CNT_W'(1)
                                           : CNT_W'(vlq_d.n);
                end
                CMD_DATA: begin
                    if (started_reg) begin
                        burst_next.bytes[0] = data_byte;
                        burst_next.cnt      = CNT_W'(1);
                    end
                end
                CMD_END: begin
                    if (started_reg) begin
                        burst_next.bytes[0] = ZERO_BYTE;
                        burst_next.bytes[1] = META_STATUS;
                        burst_next.bytes[2] = EOT_TYPE;
                        burst_next.bytes[3] = ZERO_BYTE;
                        burst_next.cnt      = CNT_W'(4);
                    end
                end
                default: begin
                end
            endcase
            if (cmd_c == CMD_END && started_reg) begin
                started_next    = 1'b0;
                prev_tick_next  = '0;
                byte_total_next = '0;
            end else begin
                byte_total_next = byte_total_reg + 32'(burst_next.cnt);
            end
            burst_valid_next = (burst_next.cnt != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_tick_reg   <= '0;
            started_reg     <= 1'b0;
            byte_total_reg  <= '0;
            burst_valid_reg <= 1'b0;
        end else begin
            prev_tick_reg   <= prev_tick_next;
            started_reg     <= started_next;
            byte_total_reg  <= byte_total_next;
            burst_valid_reg <= burst_valid_next;
        end
        burst_reg <= burst_next;
    end

endmodule

`default_nettype wire

>>> sv/mte_serializer.sv
// Burst serializer: one track byte per transaction through the output register.
`default_nettype none

module mte_serializer
    import mte_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire burst_t       burst,
    input  wire logic         burst_valid,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [7:0]        out_byte,
    output logic              out_last,
    output logic [31:0]       out_len
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic [31:0]      len_reg, len_next;
    logic             adv;
    logic             at_end;

    assign adv       = !valid_reg || out_ready;
    assign at_end    = (CNT_W'(idx_reg) == burst.cnt - CNT_W'(1));
    assign pop       = burst_valid && adv && at_end;
    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_len   = len_reg;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        byte_next  = byte_reg;
        last_next  = last_reg;
        len_next   = len_reg;
        if (adv && burst_valid) begin
            valid_next = 1'b1;
            byte_next  = burst.bytes[idx_reg];
            last_next  = at_end;
            len_next   = ((idx_reg == '0) ? burst.base : len_reg) + 32'd1;
            idx_next   = at_end ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
        last_reg <= last_next;
        len_reg  <= len_next;
    end

    a_cnt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_valid |-> burst.cnt != '0)
        else $error("burst held with no bytes");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_valid |-> CNT_W'(idx_reg) < burst.cnt)
        else $error("byte index past burst length");

    a_idle_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        !burst_valid |-> idx_reg == '0)
        else $error("byte index not cleared between bursts");

    a_len_step: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && out_ready && !last_reg |=>
            valid_reg && len_reg == $past(len_reg) + 32'd1)
        else $error("track length did not step within a burst");

endmodule

`default_nettype wire

>>> sv/midi_track_event_encoder.sv
// Top level of the MIDI track event encoder.
// Input channel s_*: one transaction per item. s_tuser[1:0] is the command
// (start event, data byte, end of track); s_tdata carries tick, sysex flag,
// sysex length and data byte. Output channel m_*: one transaction per track
// byte, m_tlast on the final byte an item causes, m_tdata holding the byte
// and the running track byte count (the MTrk chunk length).
// The first byte of an item is offered after it has passed through the burst
// register and then the output register. Throughput: one output byte per
// cycle while m_tready is high, set by the single byte-wide output register.
// An item makes 1 byte for a data byte, 4 for end of track, 1 to 4 for a
// plain event and up to 9 for a sysex event. An item that makes no bytes is
// accepted but leaves no burst. A new item is taken in the cycle the last
// byte of the previous one moves into the output register.
// Reset (aresetn low, synchronous) empties both registers and clears the
// tick, open-track flag and byte count. When m_tready is low the output
// register holds its transaction and the input stalls once a burst waits.
`default_nettype none

module midi_track_event_encoder
    import mte_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] tick, [32] sysex, [60:33] msg_length, [68:61] data_byte, [71:69] zero
    input  wire logic [71:0] s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] out_byte, [39:8] track_length
    output logic [39:0]      m_tdata,
    output logic             m_tlast
);

    burst_t      burst;
    logic        burst_valid;
    logic        pop;
    logic [7:0]  out_byte;
    logic [31:0] out_len;

    mte_encoder u_encoder (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .cmd         (s_tuser),
        .tick        (s_tdata[31:0]),
        .sysex       (s_tdata[32]),
        .msg_length  (s_tdata[60:33]),
        .data_byte   (s_tdata[68:61]),
        .pop         (pop),
        .burst       (burst),
        .burst_valid (burst_valid)
    );

    mte_serializer u_serializer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .burst       (burst),
        .burst_valid (burst_valid),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (out_byte),
        .out_last    (m_tlast),
        .out_len     (out_len)
    );

    assign m_tdata = {out_len, out_byte};

endmodule

`default_nettype wire

>>> test/midi_track_event_encoder_tb.sv
// Self-checking testbench for the MIDI track event encoder.
`timescale 1ns / 100ps

typedef struct packed {
    logic [7:0]  value;
    logic        last;
    logic [31:0] count;
} track_byte_t;

class track_byte_scoreboard;
    track_byte_t bytes_due[$];
    logic [31:0] prev_tick;
    logic [31:0] byte_count;
    logic        track_open;
    int          errors;
    int          items_taken;
    int          bytes_seen;
    int          tracks_closed;
    int          sysex_events;

    function new();
        clear_track();
        errors        = 0;
        items_taken   = 0;
        bytes_seen    = 0;
        tracks_closed = 0;
        sysex_events  = 0;
    endfunction

    function void clear_track();
        prev_tick  = '0;
        byte_count = '0;
        track_open = 1'b0;
    endfunction

    function void push_byte(input logic [7:0] value);
        track_byte_t rec;
        byte_count = byte_count + 32'd1;
        rec.value  = value;
        rec.last   = 1'b0;
        rec.count  = byte_count;
        bytes_due.push_back(rec);
    endfunction

    function void push_vlq(input logic [27:0] v);
        if ((v & mte_pkg::VLQ_GT3) != 28'd0) push_byte({1'b1, v[27:21]});
        if ((v & mte_pkg::VLQ_GT2) != 28'd0) push_byte({1'b1, v[20:14]});
        if ((v & mte_pkg::VLQ_GT1) != 28'd0) push_byte({1'b1, v[13:7]});
        push_byte({1'b0, v[6:0]});
    endfunction

    // Predicts the track bytes one accepted input transaction causes.
    function int note_item(input logic [1:0] cmd, input logic [31:0] tick,
                           input logic sysex, input logic [27:0] msg_len,
                           input logic [7:0] data);
        int          n_prior;
        logic [31:0] delta;
        track_byte_t rec;
        n_prior = bytes_due.size();
        items_taken++;
        case (cmd)
            mte_pkg::CMD_START: begin
                if (!track_open) begin
                    track_open = 1'b1;
                    prev_tick  = tick;
                end
                delta     = tick - prev_tick;
                prev_tick = tick;
                push_vlq(delta[27:0]);
                if (sysex) begin
                    sysex_events++;
                    push_byte(mte_pkg::SYSEX_STATUS);
                    push_vlq(msg_len);
                end
            end
            mte_pkg::CMD_DATA: begin
                if (track_open) push_byte(data);
            end
            mte_pkg::CMD_END: begin
                if (track_open) begin
                    push_byte(mte_pkg::ZERO_BYTE);
                    push_byte(mte_pkg::META_STATUS);
                    push_byte(mte_pkg::EOT_TYPE);
                    push_byte(mte_pkg::ZERO_BYTE);
                    tracks_closed++;
                    clear_track();
                end
            end
            default: ;
        endcase
        if (bytes_due.size() > n_prior) begin
            rec      = bytes_due.pop_back();
            rec.last = 1'b1;
            bytes_due.push_back(rec);
        end
        return bytes_due.size() - n_prior;
    endfunction

    function void check_byte(input logic [39:0] tdata, input logic tlast);
        track_byte_t want;
        bytes_seen++;
        if (bytes_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("%0t: unexpected byte %h last %b count %0d",
                         $realtime, tdata[7:0], tlast, tdata[39:8]);
            return;
        end
        want = bytes_due.pop_front();
        if (tdata[7:0] !== want.value || tlast !== want.last || tdata[39:8] !== want.count) begin
            errors++;
            if (errors <= 10)
                $display("%0t: mismatch exp byte %h last %b count %0d, got byte %h last %b count %0d",
                         $realtime, want.value, want.last, want.count,
                         tdata[7:0], tlast, tdata[39:8]);
        end
    endfunction

    function int pending();
        return bytes_due.size();
    endfunction
endclass

module midi_track_event_encoder_tb;
    import mte_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         ITEM_GOAL  = 300;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    int          tx_gap_max = 0;
    int          rx_gap_max = 0;
    int          busy_items = 0;
    logic [31:0] now_tick   = '0;

    track_byte_scoreboard sb = new();

    always #10 aclk = ~aclk;

    midi_track_event_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    task automatic send_item(input logic [1:0] cmd, input logic [31:0] tick,
                             input logic sysex, input logic [27:0] msg_len,
                             input logic [7:0] data);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, data, msg_len, sysex, tick};
        do @(posedge aclk); while (!s_tready);
        if (sb.note_item(cmd, tick, sysex, msg_len, data) > 0) busy_items++;
    endtask

    task automatic start_event(input logic [31:0] tick, input logic sysex,
                               input logic [27:0] msg_len);
        now_tick = tick;
        send_item(CMD_START, tick, sysex, msg_len, 8'($urandom));
    endtask

    task automatic data_item(input logic [1:0] cmd, input logic [7:0] data);
        send_item(cmd, $urandom, 1'($urandom), 28'($urandom), data);
    endtask

    function automatic logic [31:0] shaped_word();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // result side: random back-pressure per transaction
    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = $urandom_range(0, rx_gap_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_byte(m_tdata, m_tlast);
        end
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int n_events;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        tx_gap_max = 17;
        rx_gap_max = 17;
        data_item(CMD_DATA, 8'h5A);
        data_item(CMD_END, 8'h00);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 28'h0FF_FFFF, 8'hFF);
        start_event(32'hFFFF_FFF0, 1'b0, 28'd0);
        data_item(CMD_DATA, 8'h00);
        data_item(CMD_DATA, 8'hFF);
        start_event(32'h0000_000F, 1'b1, 28'd0);
        start_event(now_tick + 32'd127, 1'b1, 28'h0FF_FFFF);
        start_event(now_tick + 32'd128, 1'b1, 28'd127);
        start_event(now_tick + 32'd16383, 1'b1, 28'd128);
        start_event(now_tick + 32'd16384, 1'b1, 28'd16383);
        start_event(now_tick + 32'd2097151, 1'b1, 28'd16384);
        start_event(now_tick + 32'd2097152, 1'b1, 28'd2097152);
        start_event(now_tick + 32'h0FFF_FFFF, 1'b1, 28'h0FF_FFFF);
        start_event(now_tick + 32'h1000_0000, 1'b0, 28'h0FF_FFFF);
        start_event(now_tick + 32'hFFFF_FFFF, 1'b0, 28'd0);
        send_item(CMD_UNUSED, 32'd0, 1'b0, 28'd0, 8'h00);
        data_item(CMD_END, 8'hFF);
        data_item(CMD_DATA, 8'h33);
        data_item(CMD_END, 8'h00);
        start_event(32'd0, 1'b1, 28'd2097151);
        data_item(CMD_DATA, 8'hA5);
        data_item(CMD_END, 8'h00);

        // random tracks, some noise and unterminated tracks
        while (busy_items < ITEM_GOAL) begin
            case ($urandom_range(0, 3))
                0: begin tx_gap_max = 0;  rx_gap_max = 0;  end
                1: begin tx_gap_max = 17; rx_gap_max = 17; end
                2: begin tx_gap_max = 0;  rx_gap_max = 17; end
                default: begin tx_gap_max = 17; rx_gap_max = 0; end
            endcase
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3)) data_item(2'($urandom), 8'($urandom));
            end else begin
                n_events = $urandom_range(1, 6);
                repeat (n_events) begin
                    start_event(now_tick + (($urandom_range(0, 7) == 0) ? $urandom : shaped_word()),
                                $urandom_range(0, 2) == 0,
                                ($urandom_range(0, 3) == 0) ? 28'($urandom) : 28'(shaped_word()));
                    repeat ($urandom_range(0, 5)) data_item(CMD_DATA, 8'($urandom));
                    if ($urandom_range(0, 15) == 0) data_item(CMD_UNUSED, 8'($urandom));
                end
                if ($urandom_range(0, 9) != 0) data_item(CMD_END, 8'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Covered %0d input transactions, %0d track bytes, %0d closed tracks, %0d sysex events",
                 sb.items_taken, sb.bytes_seen, sb.tracks_closed, sb.sysex_events);
        $display("Mismatches: %0d, bytes still owed: %0d", sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
